FILE: sv/cftt_pkg.sv
// Shared types and constants for the command frame transfer tracker.
package cftt_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_HEADER = 3'd0;
	localparam logic [2:0] CFG_START  = 3'd1;
	localparam logic [2:0] CFG_NAME   = 3'd2;
	localparam logic [2:0] CFG_SIZE   = 3'd3;
	localparam logic [2:0] CFG_CHUNK  = 3'd4;
	localparam logic [2:0] CFG_STOP   = 3'd5;

	// configuration reset values
	localparam logic [7:0] HEADER_RST = 8'd165;
	localparam logic [7:0] START_RST  = 8'd1;
	localparam logic [7:0] NAME_RST   = 8'd2;
	localparam logic [7:0] SIZE_RST   = 8'd3;
	localparam logic [7:0] CHUNK_RST  = 8'd4;
	localparam logic [7:0] STOP_RST   = 8'd5;

	// frame verdicts
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_HEADER = 2'd1;
	localparam logic [1:0] ST_BAD_SUM    = 2'd2;
	localparam logic [1:0] ST_BAD_LEN    = 2'd3;

	// session actions
	localparam logic [2:0] ACT_IGNORED = 3'd0;
	localparam logic [2:0] ACT_STARTED = 3'd1;
	localparam logic [2:0] ACT_NAME    = 3'd2;
	localparam logic [2:0] ACT_SIZE    = 3'd3;
	localparam logic [2:0] ACT_CHUNK   = 3'd4;
	localparam logic [2:0] ACT_STOPPED = 3'd5;

	// session states
	localparam logic [2:0] SES_IDLE    = 3'd0;
	localparam logic [2:0] SES_STARTED = 3'd1;
	localparam logic [2:0] SES_NAME    = 3'd2;
	localparam logic [2:0] SES_SIZE    = 3'd3;
	localparam logic [2:0] SES_DATA    = 3'd4;
	localparam logic [2:0] SES_STOPPED = 3'd5;

	// byte positions within a frame
	localparam logic [8:0] IDX_MAX       = 9'd511;
	localparam logic [8:0] IDX_HEADER    = 9'd0;
	localparam logic [8:0] IDX_CHANNEL   = 9'd1;
	localparam logic [8:0] IDX_LENGTH    = 9'd2;
	localparam logic [8:0] IDX_HEAD_LAST = 9'd6;

	// header, channel, length and checksum bytes around the payload
	localparam logic [9:0] FRAME_OVERHEAD   = 10'd4;
	localparam logic [7:0] SIZE_FIELD_BYTES = 8'd4;
	localparam int unsigned HEAD_KEEP_BITS  = 24;

	typedef struct packed {
		logic [7:0] header_value;
		logic [7:0] start_code;
		logic [7:0] name_code;
		logic [7:0] size_code;
		logic [7:0] chunk_code;
		logic [7:0] stop_code;
	} cfg_regs_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  channel;
		logic [7:0]  length;
		logic [31:0] head;
	} frame_rslt_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  state;
		logic [31:0] file_size;
		logic [31:0] received;
	} sess_rslt_t;

endpackage

FILE: sv/cftt_frame.sv
// Per-frame capture: byte index, running sum, header fields and frame checks.
module cftt_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic [7:0]            header_value,
	output cftt_pkg::frame_rslt_t rslt
);
	import cftt_pkg::*;

	logic [8:0]  idx_q;
	logic [7:0]  sum_q;
	logic [7:0]  first_q;
	logic [7:0]  chan_q;
	logic [7:0]  len_q;
	logic [31:0] head_q;

	logic [7:0]  first_n;
	logic [7:0]  chan_n;
	logic [7:0]  len_n;
	logic [31:0] head_n;
	logic [1:0]  status;

	// capture including the current byte
	always_comb begin
		first_n = first_q;
		chan_n  = chan_q;
		len_n   = len_q;
		head_n  = head_q;
		if (idx_q == IDX_HEADER) begin
			first_n = data_byte;
		end else if (idx_q == IDX_CHANNEL) begin
			chan_n = data_byte;
		end else if (idx_q == IDX_LENGTH) begin
			len_n = data_byte;
		end else if (idx_q <= IDX_HEAD_LAST) begin
			head_n = {head_q[HEAD_KEEP_BITS-1:0], data_byte};
		end
	end

	always_comb begin
		if (first_n != header_value) begin
			status = ST_BAD_HEADER;
		end else if (sum_q != data_byte) begin
			status = ST_BAD_SUM;
		end else if ({2'b00, len_n} + FRAME_OVERHEAD != {1'b0, idx_q} + 10'd1) begin
			status = ST_BAD_LEN;
		end else begin
			status = ST_OK;
		end
	end

	assign rslt = '{status: status, channel: chan_n, length: len_n, head: head_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_q   <= '0;
			first_q <= '0;
			chan_q  <= '0;
			len_q   <= '0;
			head_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				idx_q   <= '0;
				sum_q   <= '0;
				first_q <= '0;
				chan_q  <= '0;
				len_q   <= '0;
				head_q  <= '0;
			end else begin
				first_q <= first_n;
				chan_q  <= chan_n;
				len_q   <= len_n;
				head_q  <= head_n;
				sum_q   <= sum_q + data_byte;
				if (idx_q != IDX_MAX) begin
					idx_q <= idx_q + 9'd1;
				end
			end
		end
	end

endmodule

FILE: sv/cftt_session.sv
// File-transfer session state: start, name, size, chunk and stop steps.
module cftt_session (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  cftt_pkg::frame_rslt_t frame,
	input  cftt_pkg::cfg_regs_t   cfg,
	output cftt_pkg::sess_rslt_t  rslt
);
	import cftt_pkg::*;

	logic [2:0]  state_q;
	logic [31:0] size_q;
	logic [31:0] rcvd_q;

	logic [2:0]  action;
	logic [2:0]  state_n;
	logic [31:0] size_n;
	logic [31:0] rcvd_n;
	logic        len_nz;

	assign len_nz = (frame.length != 8'd0);

	// first matching code wins, guards checked after the match
	always_comb begin
		action  = ACT_IGNORED;
		state_n = state_q;
		size_n  = size_q;
		rcvd_n  = rcvd_q;
		if (frame.status == ST_OK) begin
			if (frame.channel == cfg.start_code) begin
				if (state_q == SES_IDLE || state_q == SES_STOPPED) begin
					action  = ACT_STARTED;
					state_n = SES_STARTED;
					size_n  = '0;
					rcvd_n  = '0;
				end
			end else if (frame.channel == cfg.name_code) begin
				if (state_q == SES_STARTED && len_nz) begin
					action  = ACT_NAME;
					state_n = SES_NAME;
				end
			end else if (frame.channel == cfg.size_code) begin
				if (state_q == SES_NAME && frame.length == SIZE_FIELD_BYTES) begin
					action  = ACT_SIZE;
					state_n = SES_SIZE;
					size_n  = frame.head;
				end
			end else if (frame.channel == cfg.chunk_code) begin
				if ((state_q == SES_SIZE || state_q == SES_DATA) && len_nz) begin
					action  = ACT_CHUNK;
					state_n = SES_DATA;
					rcvd_n  = rcvd_q + {24'd0, frame.length};
				end
			end else if (frame.channel == cfg.stop_code) begin
				if (state_q == SES_DATA) begin
					action  = ACT_STOPPED;
					state_n = SES_STOPPED;
				end
			end
		end
	end

	assign rslt = '{action: action, state: state_n, file_size: size_n, received: rcvd_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SES_IDLE;
			size_q  <= '0;
			rcvd_q  <= '0;
		end else if (step) begin
			state_q <= state_n;
			size_q  <= size_n;
			rcvd_q  <= rcvd_n;
		end
	end

endmodule

FILE: sv/command_frame_transfer_tracker_core.sv
// Top level of the command frame transfer tracker: ports, stages and config registers.
// Takes command frames one byte per request on the slave stream (tlast on the
// final byte) and returns one result request per frame on the master stream.
// A frame is header byte, channel byte, length byte, payload, then a checksum
// byte equal to the 8-bit sum of all earlier bytes; the length byte must equal
// total bytes minus 4. Checks run header, checksum, length, in that order, and
// the first failure is reported. Valid frames drive the transfer session:
// start opens it (from idle or stopped) and clears size and count; name needs
// a started session and a non-empty payload; size needs the name step and
// exactly four payload bytes, read big-endian; chunk needs size or data state
// and adds the length byte to a wrapping 32-bit count; stop needs data state.
// If several code registers match, start, name, size, chunk, stop is the
// priority. Any guard failure or unknown channel reports action ignored.
// Throughput is one byte per clock while the input is not stalled: each byte is
// held in the input register, and as it moves on the frame and session logic
// update from it; a final byte also loads the result register, which drives the
// master stream. The result register only stalls the input when it still holds
// an untaken result and another final byte is waiting.
// Config writes are always ready and should only be issued while no frame is
// in flight.
module command_frame_transfer_tracker_core (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] frame_status, [9:2] channel, [12:10] action, [15:13] session_state,
	// [47:16] file_size, [79:48] bytes_received, [87:80] payload_length
	output logic [87:0] m_axis_tdata,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import cftt_pkg::*;

	cfg_regs_t   cfg_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        advance;

	// result register
	logic        res_valid_q;
	logic [87:0] res_q;

	frame_rslt_t frame;
	sess_rslt_t  sess;
	logic        frame_step;
	logic        sess_step;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{header_value: HEADER_RST, start_code: START_RST,
			           name_code: NAME_RST, size_code: SIZE_RST,
			           chunk_code: CHUNK_RST, stop_code: STOP_RST};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER: cfg_q.header_value <= cfg_data;
				CFG_START:  cfg_q.start_code   <= cfg_data;
				CFG_NAME:   cfg_q.name_code    <= cfg_data;
				CFG_SIZE:   cfg_q.size_code    <= cfg_data;
				CFG_CHUNK:  cfg_q.chunk_code   <= cfg_data;
				CFG_STOP:   cfg_q.stop_code    <= cfg_data;
				default: ; // unused indexes are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- input stage
	// Non-final bytes never need the result slot, so they always move on.
	assign advance       = valid_s1 && (!last_s1 || !res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// ---------------------------------------------------------------- frame + session
	assign frame_step = advance;
	assign sess_step  = advance && last_s1;

	cftt_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (frame_step),
		.data_byte    (data_s1),
		.last_byte    (last_s1),
		.header_value (cfg_q.header_value),
		.rslt         (frame)
	);

	cftt_session u_session (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (sess_step),
		.frame  (frame),
		.cfg    (cfg_q),
		.rslt   (sess)
	);

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (sess_step) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sess_step) begin
			res_q <= {frame.length, sess.received, sess.file_size, sess.state,
			          sess.action, frame.channel, frame.status};
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_q;

	// ---------------------------------------------------------------- checks
	// a failed frame never moves the session
	ast_bad_frame_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[12:10] == ACT_IGNORED)
		else $error("failed frame reported a session action");

	// a fresh session reports cleared size and count
	ast_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[12:10] == ACT_STARTED) |->
		(m_axis_tdata[15:13] == SES_STARTED && m_axis_tdata[79:16] == 64'd0))
		else $error("start action without cleared session values");

	// chunk action always lands in data state
	ast_chunk_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[12:10] == ACT_CHUNK) |->
		m_axis_tdata[15:13] == SES_DATA)
		else $error("chunk action outside data state");

	// a waiting final byte must hold off the input while the result is untaken
	ast_result_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && res_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while final byte blocked");

	// a result is loaded only by a final byte
	ast_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(res_valid_q)) |-> $past(valid_s1 && last_s1))
		else $error("result without a final byte");

endmodule
